// ----- hw/rtl/alsq_pkg.sv -----
// alsq_pkg: shared types, codes and constants of the adaptive level scalar quantizer
// used by every rtl file of the block; depends on nothing
package alsq_pkg;

    localparam int NUM_GROUPS_DEF = 8;          // groups carried in one activity word
    localparam int MAX_GROUPS     = 8;
    localparam int ACT_W          = 16;
    localparam int VAL_W          = 32;         // q31 latent and range width
    localparam int CNT_W          = 9;          // saturating per-level counter
    localparam int NUM_ACT_LVL    = 3;          // activity levels that are counted
    localparam int Q_SHIFT        = 31;
    localparam int LCNT_W         = 6;          // width of the largest level count (32)
    localparam int DVD_W          = LCNT_W + Q_SHIFT;   // dividend width, level count << 31
    localparam int DIV_CNT_W      = $clog2(DVD_W);
    localparam int PROD_W         = 2 * (VAL_W - 1);
    localparam int SYM_W          = 5;
    localparam int S_DATA_W       = 48;         // activity word + latent value
    localparam int M_DATA_W       = 24;         // level index + symbol + summary, byte padded
    localparam int CFG_ADDR_W     = 2;

    localparam logic [CNT_W-1:0] CNT_SAT     = '1;
    localparam logic [1:0]       ACT_UNKNOWN = 2'd3;

    // item kinds, shared by input op and output kind
    typedef enum logic [1:0] {
        OP_HDR = 2'd0,
        OP_VAL = 2'd1,
        OP_EOF = 2'd2,
        OP_RSV = 2'd3
    } t_op;

    // level index codes
    localparam logic [1:0] LVL_2  = 2'd0;
    localparam logic [1:0] LVL_3  = 2'd1;
    localparam logic [1:0] LVL_5  = 2'd2;
    localparam logic [1:0] LVL_32 = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CLINICAL  = 2'd2;

    localparam logic [VAL_W-1:0] RANGE_MIN_RST = 32'hC000_0000;
    localparam logic [VAL_W-1:0] RANGE_MAX_RST = 32'h4000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CLMP,
        ST_FIN
    } t_state;

    // control from the sequencer to the group counters
    typedef struct packed {
        logic hdr;
        logic eof;
    } t_cnt_ctrl;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } t_div_req;

    function automatic logic [LCNT_W-1:0] level_count(input logic [1:0] idx);
        logic [LCNT_W-1:0] res;
        unique case (idx)
            LVL_2:   res = 6'd2;
            LVL_3:   res = 6'd3;
            LVL_5:   res = 6'd5;
            default: res = 6'd32;
        endcase
        return res;
    endfunction

    // largest bin for a level index
    function automatic logic [SYM_W-1:0] level_top(input logic [1:0] idx);
        logic [SYM_W-1:0] res;
        unique case (idx)
            LVL_2:   res = 5'd1;
            LVL_3:   res = 5'd2;
            LVL_5:   res = 5'd4;
            default: res = 5'd31;
        endcase
        return res;
    endfunction

endpackage

// ----- hw/rtl/adaptive_level_scalar_quantizer_core.sv -----
// adaptive_level_scalar_quantizer_core: top level of the adaptive level scalar quantizer
// depends on alsq_pkg, alsq_div and alsq_group_counts
//
// takes one item at a time from a stream port and returns exactly one result item for it.
// a timestep header picks the level count from the largest group activity level
// (clinical mode forces 32 levels) and derives the bin scale (level count << 31) / range
// on a bit-serial restoring divider: 37 subtract steps, one quotient bit per cycle. a latent
// value passes through accept, one 31 x 31 multiply, clamp and result, with the multiplier
// and the clamp registered. an end of frame or a reserved op goes from accept straight to
// the result stage. s_axis_tready is high only while no item is in work; a finished result
// waits in the output register, and the next item can be accepted while that result is
// still held. configuration is to be written through the plain write port only while the
// block is idle; the block itself does not enforce it. index 3 is ignored.
module adaptive_level_scalar_quantizer_core import alsq_pkg::*; #(
    parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [VAL_W-1:0]      i_cfg_wdata,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // activity_word[15:0], latent_value[47:16]
    input  logic [1:0]            s_axis_tuser,   // op[1:0]
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // level_index[1:0], symbol[6:2],
                                                  // group_summary[22:7], zero[23]
    output logic [1:0]            m_axis_tuser    // kind[1:0]
);

    // configuration registers
    logic [VAL_W-1:0]  r_min;
    logic [VAL_W-1:0]  r_max;
    logic              r_clin;

    // sequencer and item state
    t_state            r_state;
    t_state            n_state;
    logic [1:0]        r_cur_lvl;       // level index in force
    logic [VAL_W-1:0]  r_inv;           // bin scale in force
    logic [1:0]        r_kind;
    logic [1:0]        r_lvl_out;
    logic [SYM_W-1:0]  r_sym;
    logic [ACT_W-1:0]  r_sum;
    logic [VAL_W-2:0]  r_diff;          // value above range_min, floored at 0
    logic [PROD_W-1:0] r_prod;

    // output register
    logic              r_m_valid;
    logic [1:0]        r_m_kind;
    logic [M_DATA_W-1:0] r_m_data;

    logic              w_accept;
    logic              w_out_load;
    t_op               w_op;
    logic [ACT_W-1:0]  w_act;
    logic [VAL_W-1:0]  w_val;
    logic [1:0]        w_max_act;
    logic [1:0]        w_new_lvl;
    logic [VAL_W:0]    w_range;
    logic [VAL_W-1:0]  w_divisor;
    logic [VAL_W-1:0]  w_shift;
    logic [VAL_W-2:0]  w_bin;
    logic [SYM_W-1:0]  w_top;
    logic [ACT_W-1:0]  w_summary;
    logic              w_div_done;
    logic [VAL_W-1:0]  w_quotient;
    t_div_req          w_div_req;
    t_cnt_ctrl         w_cnt_ctrl;

    assign w_op  = t_op'(s_axis_tuser);
    assign w_act = s_axis_tdata[ACT_W-1:0];
    assign w_val = s_axis_tdata[ACT_W +: VAL_W];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= RANGE_MIN_RST;
            r_max  <= RANGE_MAX_RST;
            r_clin <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RANGE_MIN: r_min  <= i_cfg_wdata;
                REG_RANGE_MAX: r_max  <= i_cfg_wdata;
                REG_CLINICAL:  r_clin <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // header: largest activity level, an unknown level maps to two levels
    always_comb begin
        w_max_act = 2'd0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (w_act[2*g +: 2] > w_max_act) begin
                w_max_act = w_act[2*g +: 2];
            end
        end
    end

    assign w_new_lvl = r_clin ? LVL_32 : ((w_max_act == ACT_UNKNOWN) ? LVL_2 : w_max_act);

    // range in 33 bits, empty or inverted range counts as 1
    assign w_range   = {r_max[VAL_W-1], r_max} - {r_min[VAL_W-1], r_min};
    assign w_divisor = (w_range[VAL_W] || w_range == '0) ? VAL_W'(1) : w_range[VAL_W-1:0];

    // value: wrapped difference, negative floored at 0
    assign w_shift = w_val - r_min;

    // clamp of the product's bin to the largest bin of the level in force
    assign w_bin = r_prod[PROD_W-1:Q_SHIFT];
    assign w_top = level_top(r_cur_lvl);

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_HDR:  n_state = ST_DIV;
                        OP_VAL:  n_state = ST_MUL;
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL:  n_state = ST_CLMP;
            ST_CLMP: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_axis_tready      = (r_state == ST_IDLE);
        w_accept           = s_axis_tvalid && (r_state == ST_IDLE);
        w_out_load         = (r_state == ST_FIN) && (!r_m_valid || m_axis_tready);
        w_div_req.start    = w_accept && (w_op == OP_HDR);
        w_div_req.dividend = {level_count(w_new_lvl), Q_SHIFT'(0)};
        w_div_req.divisor  = w_divisor;
        w_cnt_ctrl.hdr     = w_accept && (w_op == OP_HDR);
        w_cnt_ctrl.eof     = w_accept && (w_op == OP_EOF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cur_lvl <= LVL_2;
            r_inv     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cnt_ctrl.hdr) begin
                r_cur_lvl <= w_new_lvl;
            end
            if (w_div_done) begin
                r_inv <= w_quotient;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= s_axis_tuser;
            r_lvl_out <= (w_op == OP_HDR) ? w_new_lvl : r_cur_lvl;
            r_sum     <= (w_op == OP_EOF) ? w_summary : '0;
            r_sym     <= '0;
            r_diff    <= w_shift[VAL_W-1] ? '0 : w_shift[VAL_W-2:0];
        end
        if (r_state == ST_MUL) begin
            // a negative scale gives bin 0
            r_prod <= r_inv[VAL_W-1] ? '0 : r_diff * r_inv[VAL_W-2:0];
        end
        if (r_state == ST_CLMP) begin
            r_sym <= (w_bin > {{(VAL_W-1-SYM_W){1'b0}}, w_top}) ? w_top : w_bin[SYM_W-1:0];
        end
        if (w_out_load) begin
            r_m_kind <= r_kind;
            r_m_data <= {1'b0, r_sum, r_sym, r_lvl_out};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

    alsq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    alsq_group_counts #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_counts (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_cnt_ctrl),
        .i_act     (w_act),
        .o_summary (w_summary)
    );

    // a header item always goes to the divider
    a_hdr_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_ctrl.hdr |=> r_state == ST_DIV)
        else $error("header item did not start the divider");

    // the divider only finishes while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide state");

    // only latent value results carry a symbol
    a_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != OP_VAL |-> m_axis_tdata[6:2] == '0)
        else $error("symbol on a result that is not a latent value");

    // symbol never leaves the bins of the reported level
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == OP_VAL
            |-> m_axis_tdata[6:2] <= level_top(m_axis_tdata[1:0]))
        else $error("symbol beyond the largest bin of its level");

    // only an end of frame carries a summary
    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != OP_EOF |-> m_axis_tdata[22:7] == '0)
        else $error("summary on a result that is not an end of frame");

endmodule

// ----- hw/rtl/alsq_div.sv -----
// alsq_div: bit-serial restoring divider, one quotient bit per cycle
// depends on alsq_pkg
module alsq_div import alsq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [VAL_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [VAL_W-1:0]     r_dvs;
    logic [VAL_W-1:0]     r_rem;
    logic [VAL_W-1:0]     r_quo;

    logic [VAL_W:0]       w_trial;
    logic [VAL_W:0]       w_diff;
    logic                 w_ge;

    // one shared subtract and compare per step
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = ~w_diff[VAL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[VAL_W-1:0] : w_trial[VAL_W-1:0];
            // upper quotient bits fall off, only the low word is kept
            r_quo <= {r_quo[VAL_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/alsq_group_counts.sv -----
// alsq_group_counts: saturating per-group activity level counters and frame summary
// depends on alsq_pkg
module alsq_group_counts import alsq_pkg::*; #(
    parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cnt_ctrl        i_ctrl,
    input  logic [ACT_W-1:0] i_act,
    output logic [ACT_W-1:0] o_summary
);

    logic [CNT_W-1:0] r_cnt [NUM_GROUPS][NUM_ACT_LVL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                for (int l = 0; l < NUM_ACT_LVL; l++) begin
                    r_cnt[g][l] <= '0;
                end
            end
        end else if (i_ctrl.eof) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                for (int l = 0; l < NUM_ACT_LVL; l++) begin
                    r_cnt[g][l] <= '0;
                end
            end
        end else if (i_ctrl.hdr) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                for (int l = 0; l < NUM_ACT_LVL; l++) begin
                    if (i_act[2*g +: 2] == 2'(l) && r_cnt[g][l] != CNT_SAT) begin
                        r_cnt[g][l] <= r_cnt[g][l] + 1'b1;
                    end
                end
            end
        end
    end

    // most frequent level per group, ties to the lower level
    always_comb begin
        logic [1:0]       best;
        logic [CNT_W-1:0] best_cnt;
        o_summary = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            best     = 2'd0;
            best_cnt = r_cnt[g][0];
            if (r_cnt[g][1] > best_cnt) begin
                best     = 2'd1;
                best_cnt = r_cnt[g][1];
            end
            if (r_cnt[g][2] > best_cnt) begin
                best = 2'd2;
            end
            o_summary[2*g +: 2] = best;
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for adaptive_level_scalar_quantizer_core, predicts each result item
// in a bit-accurate quantizer model and compares it field by field; depends on alsq_pkg and the rtl
module tb;
    import alsq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no item moving on either side
    localparam int HOLD_AFTER     = 150;    // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_BACKLOG   = 8;      // items still queued so the sender keeps offering

    typedef struct packed {
        t_op         op;
        logic [15:0] act;
        logic [31:0] val;
    } t_qitem;

    typedef struct packed {
        t_op         kind;
        logic [1:0]  level;
        logic [4:0]  sym;
        logic [15:0] summary;
    } t_qres;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [VAL_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    adaptive_level_scalar_quantizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // activity_word[15:0], latent_value[47:16]
        .s_axis_tuser  (s_axis_tuser),    // op[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // level_index[1:0], symbol[6:2], group_summary[22:7]
        .m_axis_tuser  (m_axis_tuser)     // kind[1:0]
    );

    always #5 i_clk = ~i_clk;

    // quantizer state as the bench sees it
    logic [31:0] cfg_range_min = RANGE_MIN_RST;
    logic [31:0] cfg_range_max = RANGE_MAX_RST;
    logic        cfg_clinical  = 1'b0;
    logic [1:0]  cur_level     = LVL_2;
    logic [31:0] cur_inv       = '0;
    logic [CNT_W-1:0] lvl_count [8][3];

    t_qitem queued_items[$];     // input items not yet offered
    t_qres  awaited_results[$];  // predicted results not yet returned
    t_qitem offered;
    bit     steady       = 1'b0; // no idling on either side while set
    int     faults       = 0;
    int     results_seen = 0;
    int     hold_left    = 0;
    bit     hold_done    = 1'b0;
    int     quiet        = 0;

    function automatic int levels_for(input logic [1:0] idx);
        case (idx)
            LVL_2:   return 2;
            LVL_3:   return 3;
            LVL_5:   return 5;
            default: return 32;
        endcase
    endfunction

    // advances the quantizer state by one item and returns the result it causes
    function automatic t_qres quantize_step(input t_qitem it);
        t_qres       r;
        logic [1:0]  a;
        logic [1:0]  amax;
        logic [1:0]  best;
        logic [31:0] wrapped;
        longint      span;
        longint      lo;
        longint      diff;
        longint      prod;
        longint      bin;
        longint      top;
        r.kind    = it.op;
        r.sym     = '0;
        r.summary = '0;
        case (it.op)
            OP_HDR: begin
                amax = 2'd0;
                for (int g = 0; g < 8; g++) begin
                    a = it.act[2*g +: 2];
                    if (a > amax) amax = a;
                    if (a != ACT_UNKNOWN && lvl_count[g][a] != CNT_SAT)
                        lvl_count[g][a] = lvl_count[g][a] + 1'b1;
                end
                // unknown level wins the maximum but selects the smallest level count
                if (cfg_clinical) cur_level = LVL_32;
                else if (amax == ACT_UNKNOWN) cur_level = LVL_2;
                else cur_level = amax;
                span = $signed(cfg_range_max);
                lo   = $signed(cfg_range_min);
                span = span - lo;
                if (span <= 0) span = 1;
                cur_inv = 32'((longint'(levels_for(cur_level)) << Q_SHIFT) / span);
            end
            OP_VAL: begin
                wrapped = it.val - cfg_range_min;
                diff    = $signed(wrapped);
                if (diff < 0) diff = 0;
                prod = $signed(cur_inv);
                prod = prod * diff;
                top  = levels_for(cur_level) - 1;
                if (prod > 0) begin
                    bin   = prod >>> Q_SHIFT;
                    r.sym = (bin > top) ? 5'(top) : 5'(bin);
                end
            end
            OP_EOF: begin
                // most frequent level per group, lower level on a tie
                for (int g = 0; g < 8; g++) begin
                    best = 2'd0;
                    if (lvl_count[g][1] > lvl_count[g][best]) best = 2'd1;
                    if (lvl_count[g][2] > lvl_count[g][best]) best = 2'd2;
                    r.summary[2*g +: 2] = best;
                    for (int l = 0; l < 3; l++) lvl_count[g][l] = '0;
                end
            end
            default: ;
        endcase
        r.level = cur_level;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            faults++;
        end
    endfunction

    // input side: predicts on every accepted item, then offers the next one or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(quantize_step(offered));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (queued_items.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
                    offered = queued_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered.val, offered.act};
                    s_axis_tuser  <= offered.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: checks every accepted result, stalls at random and once for a long stretch
    always @(posedge i_clk) begin
        t_qres want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("result item with no prediction waiting: kind 0x%0h", m_axis_tuser);
                    faults++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    compare_field("level_index", 32'(want.level), 32'(m_axis_tdata[1:0]));
                    compare_field("symbol", 32'(want.sym), 32'(m_axis_tdata[6:2]));
                    compare_field("group_summary", 32'(want.summary),
                                  32'(m_axis_tdata[22:7]));
                    compare_field("padding", 32'd0, 32'(m_axis_tdata[23]));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER
                         && queued_items.size() >= HOLD_BACKLOG) begin
                // long hold-off so the block fills up and drops its input ready
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 29);
            end
        end
    end

    // watchdog on cycles in which no item moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic add_item(input t_op op, input logic [15:0] act, input logic [31:0] val);
        t_qitem it;
        it.op  = op;
        it.act = act;
        it.val = val;
        queued_items.push_back(it);
    endtask

    // waits until every item is taken and every result has come back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (queued_items.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_RANGE_MIN: cfg_range_min = data;
            REG_RANGE_MAX: cfg_range_max = data;
            REG_CLINICAL:  cfg_clinical  = data[0];
            default: ;
        endcase
    endtask

    task automatic set_ranges(input logic [31:0] rmin, input logic [31:0] rmax,
                              input logic clinical);
        wait_idle();
        write_reg(REG_RANGE_MIN, rmin);
        write_reg(REG_RANGE_MAX, rmax);
        write_reg(REG_CLINICAL, {31'd0, clinical});
    endtask

    function automatic logic [15:0] pick_activity();
        logic [15:0] w;
        int          peak;
        if ($urandom_range(99) < 15) return 16'($urandom);
        peak = $urandom_range(2);
        for (int g = 0; g < 8; g++)
            w[2*g +: 2] = ($urandom_range(19) == 0) ? ACT_UNKNOWN : 2'($urandom_range(peak));
        return w;
    endfunction

    // mostly inside the configured range, some at its edges, the rest anywhere
    function automatic logic [31:0] pick_latent();
        longint lo;
        longint hi;
        int     sel;
        lo  = $signed(cfg_range_min);
        hi  = $signed(cfg_range_max);
        sel = $urandom_range(99);
        if (sel < 55 && hi > lo) return 32'(lo + longint'($urandom) % (hi - lo + 1));
        if (sel < 75) begin
            case ($urandom_range(5))
                0: return cfg_range_min;
                1: return cfg_range_min - 1;
                2: return cfg_range_max;
                3: return cfg_range_max + 1;
                4: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // frames of timesteps, each a header and its values, closed by an end of frame;
    // a few frames are left open and a few carry stray items
    task automatic fill_random(input int target);
        int added;
        int steps;
        int vals;
        added = 0;
        while (added < target) begin
            steps = $urandom_range(1, 4);
            for (int k = 0; k < steps; k++) begin
                add_item(OP_HDR, pick_activity(), $urandom);
                added++;
                vals = ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 10);
                for (int j = 0; j < vals; j++) begin
                    add_item(OP_VAL, 16'($urandom), pick_latent());
                    added++;
                    if ($urandom_range(39) == 0) add_item(OP_RSV, 16'($urandom), $urandom);
                    if ($urandom_range(79) == 0) begin
                        add_item(OP_EOF, 16'($urandom), $urandom);
                        added++;
                    end
                end
            end
            if ($urandom_range(9) != 0) begin
                add_item(OP_EOF, 16'($urandom), $urandom);
                added++;
            end
        end
    endtask

    initial begin
        logic [31:0] r;
        logic [31:0] q;
        for (int g = 0; g < 8; g++)
            for (int l = 0; l < 3; l++) lvl_count[g][l] = '0;

        // directed items on the reset settings
        add_item(OP_VAL, 16'h0000, 32'h0000_0000);   // value before any header
        add_item(OP_RSV, 16'hFFFF, 32'hFFFF_FFFF);   // reserved op changes nothing
        add_item(OP_EOF, 16'h0000, 32'h0000_0000);   // summary of empty counts
        add_item(OP_HDR, 16'h0000, 32'h0000_0000);
        add_item(OP_VAL, 16'hFFFF, 32'h8000_0000);   // far below range_min, floored
        add_item(OP_VAL, 16'h0000, 32'hBFFF_FFFF);   // just below range_min
        add_item(OP_VAL, 16'h0000, 32'hC000_0000);
        add_item(OP_VAL, 16'h0000, 32'h7FFF_FFFF);   // wraps past the sign bit, floored to bin 0
        add_item(OP_HDR, 16'h5555, 32'hFFFF_FFFF);
        add_item(OP_VAL, 16'h0000, 32'h0000_0000);
        add_item(OP_VAL, 16'h0000, 32'h3FFF_FFFF);
        add_item(OP_HDR, 16'hAAAA, 32'h0000_0000);
        add_item(OP_VAL, 16'h0000, 32'h2000_0000);
        add_item(OP_VAL, 16'h0000, 32'h7FFF_FFFF);
        add_item(OP_HDR, 16'hFFFF, 32'h0000_0000);   // every group unknown
        add_item(OP_HDR, 16'h001B, 32'h0000_0000);   // unknown level beats level 2
        add_item(OP_VAL, 16'h0000, 32'h4000_0000);
        add_item(OP_RSV, 16'h0000, 32'h0000_0000);
        add_item(OP_EOF, 16'h0000, 32'h0000_0000);   // ties go to the lower level
        add_item(OP_EOF, 16'hFFFF, 32'hFFFF_FFFF);   // counts were cleared

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tiny range: the scale overflows and reads as negative
        set_ranges(32'h0000_0000, 32'h0000_0003, 1'b0);
        add_item(OP_HDR, 16'hAAAA, 32'h0000_0000);
        add_item(OP_VAL, 16'h0000, 32'h0000_0002);
        add_item(OP_VAL, 16'h0000, 32'h7FFF_FFFF);
        // empty range under clinical mode
        set_ranges(32'h1234_5678, 32'h1234_5678, 1'b1);
        add_item(OP_HDR, 16'h0000, 32'h0000_0000);
        add_item(OP_VAL, 16'h0000, 32'h7FFF_FFFF);

        // random frames across several settings, the extremes among them
        set_ranges(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        fill_random(40);
        set_ranges(RANGE_MIN_RST, RANGE_MAX_RST, 1'b1);
        fill_random(40);
        r = $urandom & 32'h3FFF_FFFF;
        set_ranges(r, r + 32'd3, 1'b0);
        fill_random(40);
        r = $urandom;
        set_ranges(r, r, 1'($urandom_range(1)));
        steady = 1'b1;
        fill_random(40);
        set_ranges(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        steady = 1'b0;
        fill_random(40);
        for (int p = 0; p < 3; p++) begin
            r = $urandom;
            q = $urandom;
            if (p == 0 && $signed(r) > $signed(q)) set_ranges(q, r, 1'b0);
            else set_ranges(r, q, 1'($urandom_range(1)));
            fill_random(40);
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (faults == 0 && awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
